// ===== rtl/core/tcc_pkg.sv =====
// ----------------------------------------------------------------------------
// tcc_pkg
// Shared widths, character codes and default geometry for the text console.
// ----------------------------------------------------------------------------
package tcc_pkg;

	// default screen geometry
	localparam int COLUMNS_DEF    = 80;
	localparam int SCROLL_ROW_DEF = 24;

	// field widths of the request and response items
	localparam int TYPE_W = 1;
	localparam int CHAR_W = 8;
	localparam int ATTR_W = 8;
	localparam int ROW_W  = 5;
	localparam int COL_W  = 7;
	localparam int POS_W  = 11;

	// width of a linear cell index, wide enough for any allowed geometry
	localparam int IDX_W  = 12;

	// request types
	localparam logic [TYPE_W-1:0] REQ_PUT  = 1'b0;
	localparam logic [TYPE_W-1:0] REQ_READ = 1'b1;

	// control characters
	localparam logic [CHAR_W-1:0] CODE_BS = 8'h08;
	localparam logic [CHAR_W-1:0] CODE_NL = 8'h0A;
	localparam logic [CHAR_W-1:0] CODE_CR = 8'h0D;

	// blank cell contents
	localparam logic [CHAR_W-1:0] BLANK_CHAR     = 8'h20;
	localparam logic [ATTR_W-1:0] WHITE_ATTR     = 8'h07;
	localparam logic [ATTR_W-1:0] BLACK_ATTR     = 8'h00;
	localparam logic [ATTR_W-1:0] TEXT_COLOR_RST = 8'h07;

endpackage

// ===== rtl/core/tcc_if.sv =====
// ----------------------------------------------------------------------------
// tcc_req_if / tcc_rsp_if
// Valid/ready channels for console requests and their response items.
// ----------------------------------------------------------------------------
interface tcc_req_if;
	logic                        valid;
	logic                        ready;
	logic [tcc_pkg::TYPE_W-1:0]  req_type;
	logic [tcc_pkg::CHAR_W-1:0]  char_code;
	logic [tcc_pkg::ROW_W-1:0]   read_row;
	logic [tcc_pkg::COL_W-1:0]   read_col;

	modport source (output valid, req_type, char_code, read_row, read_col, input ready);
	modport sink   (input valid, req_type, char_code, read_row, read_col, output ready);
endinterface

interface tcc_rsp_if;
	logic                        valid;
	logic                        ready;
	logic [tcc_pkg::CHAR_W-1:0]  cell_char;
	logic [tcc_pkg::ATTR_W-1:0]  cell_attr;
	logic [tcc_pkg::POS_W-1:0]   cursor_position;
	logic                        did_scroll;

	modport source (output valid, cell_char, cell_attr, cursor_position, did_scroll,
		input ready);
	modport sink   (input valid, cell_char, cell_attr, cursor_position, did_scroll,
		output ready);
endinterface

// ===== rtl/core/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// Text console cell store with cursor handling, scrolling and cell reads.
// ----------------------------------------------------------------------------
// Usage:
//   req (sink)  : one item per request. req_type put writes/interprets
//                 char_code at the cursor (backspace, newline, return handled);
//                 req_type read returns the cell at read_row/read_col.
//   rsp (source): one item per request with cell_char/cell_attr (zero for a
//                 put), the cursor position after the request and did_scroll.
//   cfg_we/cfg_wdata: writes text_color, the attribute used by puts.
// Sequencing: a put goes from EXEC to DONE; a read that touches the RAM
//   goes EXEC, RDATA, DONE (the bottom row or outside the screen skip
//   RDATA). From DONE the result moves to the output register and only then
//   is the next request accepted. A put that scrolls walks the whole store
//   through the single RAM read and write port in ST_SCROLL before DONE.
// Reset: cursor goes home and a clearing pass writes every cell of rows
//   0..SCROLL_ROW-1 with a white space, with req.ready low. Row
//   SCROLL_ROW is never written and reads as a space on black without
//   touching the RAM.
// Stall: a finished response waits in the output register; the next request
//   is accepted and worked on meanwhile, and its result is held until the
//   output register frees up.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll #(
	parameter int COLUMNS    = tcc_pkg::COLUMNS_DEF,
	parameter int SCROLL_ROW = tcc_pkg::SCROLL_ROW_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	tcc_req_if.sink                    req,
	tcc_rsp_if.source                  rsp,
	input  logic                       cfg_we,
	input  logic [tcc_pkg::ATTR_W-1:0] cfg_wdata
);

	localparam int DEPTH  = SCROLL_ROW * COLUMNS;
	localparam int KEEP   = (SCROLL_ROW - 1) * COLUMNS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int IW     = tcc_pkg::IDX_W;
	localparam int RW     = tcc_pkg::ROW_W;
	localparam int CW     = tcc_pkg::COL_W;
	localparam int PW     = tcc_pkg::POS_W;

	typedef enum logic [5:0] {
		ST_CLEAR  = 6'b000001,
		ST_IDLE   = 6'b000010,
		ST_EXEC   = 6'b000100,
		ST_RDATA  = 6'b001000,
		ST_SCROLL = 6'b010000,
		ST_DONE   = 6'b100000
	} state_t;

	state_t state_q;

	logic [tcc_pkg::ATTR_W-1:0] color_q;
	logic [RW-1:0]              cur_row_q;
	logic [CW-1:0]              cur_col_q;
	logic [ADDR_W-1:0]          scan_q;

	// captured request
	logic [tcc_pkg::TYPE_W-1:0] rq_type_q;
	logic [tcc_pkg::CHAR_W-1:0] rq_char_q;
	logic [RW-1:0]              rq_row_q;
	logic [CW-1:0]              rq_col_q;

	// finished result waiting for the output register
	logic [tcc_pkg::CHAR_W-1:0] res_char_q;
	logic [tcc_pkg::ATTR_W-1:0] res_attr_q;
	logic                       res_scroll_q;

	// output register
	logic                       out_vld_q;
	logic [tcc_pkg::CHAR_W-1:0] out_char_q;
	logic [tcc_pkg::ATTR_W-1:0] out_attr_q;
	logic [PW-1:0]              out_pos_q;
	logic                       out_scroll_q;

	// scroll copy write stage
	logic                       cp_vld_s1;
	logic [ADDR_W-1:0]          cp_addr_s1;
	logic                       cp_blank_s1;

	// RAM ports
	logic                       we_chr;
	logic                       we_atr;
	logic [ADDR_W-1:0]          waddr;
	logic [tcc_pkg::CHAR_W-1:0] wchr;
	logic [tcc_pkg::ATTR_W-1:0] watr;
	logic                       re;
	logic [ADDR_W-1:0]          raddr;
	logic [tcc_pkg::CHAR_W-1:0] rchr;
	logic [tcc_pkg::ATTR_W-1:0] ratr;

	// datapath
	logic                       in_acc;
	logic                       out_free;
	logic [IW-1:0]              cur_idx;
	logic [IW-1:0]              rd_idx;
	logic                       rd_col_ok;
	logic                       rd_in_mem;
	logic                       rd_last_row;
	logic [CW:0]                col_inc;
	logic [RW-1:0]              nxt_row;
	logic [CW-1:0]              nxt_col;
	logic                       nxt_scroll;
	logic                       is_ctrl;
	logic                       bs_ok;

	assign in_acc   = req.valid && req.ready;
	assign out_free = !out_vld_q || rsp.ready;

	// cell indexes from row/column
	assign cur_idx = IW'(cur_row_q) * IW'(COLUMNS) + IW'(cur_col_q);
	assign rd_idx  = IW'(rq_row_q) * IW'(COLUMNS) + IW'(rq_col_q);

	// read range checks
	assign rd_col_ok   = {1'b0, rq_col_q} < (CW + 1)'(COLUMNS);
	assign rd_in_mem   = rd_col_ok && (rq_row_q < RW'(SCROLL_ROW));
	assign rd_last_row = rd_col_ok && (rq_row_q == RW'(SCROLL_ROW));

	assign is_ctrl = (rq_char_q == tcc_pkg::CODE_NL) || (rq_char_q == tcc_pkg::CODE_BS) ||
		(rq_char_q == tcc_pkg::CODE_CR);
	assign bs_ok   = (rq_char_q == tcc_pkg::CODE_BS) && (cur_col_q != '0);
	assign col_inc = {1'b0, cur_col_q} + 1'b1;

	// next cursor for a put
	always_comb begin
		nxt_row    = cur_row_q;
		nxt_col    = cur_col_q;
		nxt_scroll = 1'b0;
		unique case (rq_char_q)
			tcc_pkg::CODE_NL: begin
				nxt_row = cur_row_q + 1'b1;
				nxt_col = '0;
			end
			tcc_pkg::CODE_BS: begin
				if (bs_ok) begin
					nxt_col = cur_col_q - 1'b1;
				end
			end
			tcc_pkg::CODE_CR: begin
				nxt_col = '0;
			end
			default: begin
				if (col_inc == (CW + 1)'(COLUMNS)) begin
					nxt_row = cur_row_q + 1'b1;
					nxt_col = '0;
				end else begin
					nxt_col = col_inc[CW-1:0];
				end
			end
		endcase
		if (nxt_row == RW'(SCROLL_ROW)) begin
			nxt_row    = RW'(SCROLL_ROW - 1);
			nxt_scroll = 1'b1;
		end
	end

	// RAM write port select
	always_comb begin
		we_chr = 1'b0;
		we_atr = 1'b0;
		waddr  = '0;
		wchr   = tcc_pkg::BLANK_CHAR;
		watr   = tcc_pkg::WHITE_ATTR;
		priority if (cp_vld_s1) begin
			we_chr = 1'b1;
			we_atr = 1'b1;
			waddr  = cp_addr_s1;
			if (!cp_blank_s1) begin
				wchr = rchr;
				watr = ratr;
			end
		end else if (state_q == ST_CLEAR) begin
			we_chr = 1'b1;
			we_atr = 1'b1;
			waddr  = scan_q;
		end else if (state_q == ST_EXEC && rq_type_q == tcc_pkg::REQ_PUT) begin
			if (bs_ok) begin
				we_chr = 1'b1;
				waddr  = ADDR_W'(cur_idx - 1'b1);
			end else if (!is_ctrl) begin
				we_chr = 1'b1;
				we_atr = 1'b1;
				waddr  = ADDR_W'(cur_idx);
				wchr   = rq_char_q;
				watr   = color_q;
			end
		end else begin
			// no write this cycle
			we_chr = 1'b0;
		end
	end

	// RAM read port select
	always_comb begin
		re    = 1'b0;
		raddr = '0;
		priority if (state_q == ST_EXEC && rq_type_q == tcc_pkg::REQ_READ && rd_in_mem) begin
			re    = 1'b1;
			raddr = ADDR_W'(rd_idx);
		end else if (state_q == ST_SCROLL && scan_q < ADDR_W'(KEEP)) begin
			re    = 1'b1;
			raddr = scan_q + ADDR_W'(COLUMNS);
		end else begin
			// no read this cycle
			re = 1'b0;
		end
	end

	tcc_ram #(.WIDTH(tcc_pkg::CHAR_W), .DEPTH(DEPTH)) u_chr_ram (
		.clk   (clk),
		.we    (we_chr),
		.waddr (waddr),
		.wdata (wchr),
		.re    (re),
		.raddr (raddr),
		.rdata (rchr)
	);

	tcc_ram #(.WIDTH(tcc_pkg::ATTR_W), .DEPTH(DEPTH)) u_atr_ram (
		.clk   (clk),
		.we    (we_atr),
		.waddr (waddr),
		.wdata (watr),
		.re    (re),
		.raddr (raddr),
		.rdata (ratr)
	);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_q <= tcc_pkg::TEXT_COLOR_RST;
		end else if (cfg_we) begin
			color_q <= cfg_wdata;
		end
	end

	// scroll copy stage: the write follows in the cycle after its read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_vld_s1 <= 1'b0;
		end else begin
			cp_vld_s1 <= (state_q == ST_SCROLL);
		end
	end

	always_ff @(posedge clk) begin
		cp_addr_s1  <= scan_q;
		cp_blank_s1 <= (scan_q >= ADDR_W'(KEEP));
	end

	// control sequencer and cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			scan_q    <= '0;
			cur_row_q <= '0;
			cur_col_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					scan_q <= '0;
					if (rq_type_q == tcc_pkg::REQ_READ) begin
						state_q <= rd_in_mem ? ST_RDATA : ST_DONE;
					end else begin
						cur_row_q <= nxt_row;
						cur_col_q <= nxt_col;
						state_q   <= nxt_scroll ? ST_SCROLL : ST_DONE;
					end
				end
				ST_RDATA: begin
					state_q <= ST_DONE;
				end
				ST_SCROLL: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and result assembly
	always_ff @(posedge clk) begin
		if (in_acc) begin
			rq_type_q <= req.req_type;
			rq_char_q <= req.char_code;
			rq_row_q  <= req.read_row;
			rq_col_q  <= req.read_col;
		end
		if (state_q == ST_EXEC) begin
			res_scroll_q <= (rq_type_q == tcc_pkg::REQ_PUT) && nxt_scroll;
			res_char_q   <= rd_last_row && rq_type_q == tcc_pkg::REQ_READ
				? tcc_pkg::BLANK_CHAR : '0;
			res_attr_q   <= tcc_pkg::BLACK_ATTR;
		end else if (state_q == ST_RDATA) begin
			res_char_q <= rchr;
			res_attr_q <= ratr;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			out_char_q   <= res_char_q;
			out_attr_q   <= res_attr_q;
			out_pos_q    <= cur_idx[PW-1:0];
			out_scroll_q <= res_scroll_q;
		end
	end

	assign req.ready           = (state_q == ST_IDLE);
	assign rsp.valid           = out_vld_q;
	assign rsp.cell_char       = out_char_q;
	assign rsp.cell_attr       = out_attr_q;
	assign rsp.cursor_position = out_pos_q;
	assign rsp.did_scroll      = out_scroll_q;

endmodule

// ===== rtl/core/tcc_ram.sv =====
// ----------------------------------------------------------------------------
// tcc_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module tcc_ram #(
	parameter int WIDTH  = 8,
	parameter int DEPTH  = 16,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== rtl/core/tcc_chk.sv =====
// ----------------------------------------------------------------------------
// tcc_chk
// Port-level checks for the text console, bound to the top level.
// ----------------------------------------------------------------------------
module tcc_chk #(
	parameter int COLUMNS    = tcc_pkg::COLUMNS_DEF,
	parameter int SCROLL_ROW = tcc_pkg::SCROLL_ROW_DEF
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        req_valid,
	input logic                        req_ready,
	input logic                        rsp_valid,
	input logic                        rsp_ready,
	input logic [tcc_pkg::CHAR_W-1:0]  rsp_char,
	input logic [tcc_pkg::ATTR_W-1:0]  rsp_attr,
	input logic [tcc_pkg::POS_W-1:0]   rsp_pos,
	input logic                        rsp_scroll
);

	localparam int LO   = (SCROLL_ROW - 1) * COLUMNS;
	localparam int HI   = SCROLL_ROW * COLUMNS;
	localparam bit WRAP = HI > (1 << tcc_pkg::POS_W);

	// items accepted but not yet delivered
	logic [1:0] pend_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
		end
	end

	// a response always belongs to an accepted item
	a_rsp_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> pend_q != 2'd0)
		else $error("response without an accepted item");

	// at most one item in work and one in the output register
	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q != 2'd3)
		else $error("too many items in flight");

	// a stalled response holds its contents
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_char) && $stable(rsp_attr)
			&& $stable(rsp_pos) && $stable(rsp_scroll))
		else $error("stalled response changed");

	// after a scroll the cursor sits on the last scrolling row
	a_scroll_row: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_scroll |-> WRAP || (int'(rsp_pos) >= LO && int'(rsp_pos) < HI))
		else $error("cursor not on last row after scroll");

endmodule

bind text_console_cursor_scroll tcc_chk #(
	.COLUMNS    (COLUMNS),
	.SCROLL_ROW (SCROLL_ROW)
) u_tcc_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.rsp_char   (rsp.cell_char),
	.rsp_attr   (rsp.cell_attr),
	.rsp_pos    (rsp.cursor_position),
	.rsp_scroll (rsp.did_scroll)
);
